@@ src/sptf_pkg.sv @@
// sptf_pkg: shared widths, operation and status codes for the sorted filter table
// no dependencies; used by sorted_prefix_filter_table_unit
package sptf_pkg;

  localparam int KEY_W           = 32;
  localparam int DATA_W          = 64;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;
  localparam int TABLE_DEPTH_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REPLACED = 2'd1,
    STAT_REMOVED  = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

endpackage

@@ src/sptf_ram.sv @@
// sptf_ram: generic single write port, single read port ram with registered read
// no dependencies
module sptf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sorted_prefix_filter_table_unit.sv @@
// sorted_prefix_filter_table_unit: table of keyed entries kept in ascending key order
// depends on sptf_pkg and sptf_ram
//
// usage:
//   input channel in_valid_i / in_stall_o carries one update request
//   (operation_i, sequence_key_i, entry_data_i); output channel out_valid_o /
//   out_stall_i returns one result per request (status_o, key_found_o,
//   entry_count_o). a request is taken when valid is high and stall is low.
//   one request is worked at a time; in_stall_o is high while it is busy.
//   remove all and the unused code go from idle straight to the result state.
//   add and remove scan the table through one ram read port and one key
//   comparator, with a read and a compare for each entry passed; an insert
//   or a hit remove then shifts entries one slot at a time, read then write.
//   the result sits in an output register; a stall there holds it and the
//   block keeps working the next request, waiting only when a second result
//   is ready before the first is taken.
//   reset empties the table at once (the fill count goes to zero) with no
//   clearing pass; the ram contents are never read past the fill count.
module sorted_prefix_filter_table_unit #(
  parameter int TABLE_DEPTH = sptf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sptf_pkg::OP_W-1:0]      operation_i,
  input  logic [sptf_pkg::KEY_W-1:0]     sequence_key_i,
  input  logic [sptf_pkg::DATA_W-1:0]    entry_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sptf_pkg::STATUS_W-1:0]  status_o,
  output logic                           key_found_o,
  output logic [sptf_pkg::COUNT_W-1:0]   entry_count_o
);

  import sptf_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = KEY_W + DATA_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CMP = 7'b0000100,
    S_DECIDE   = 7'b0001000,
    S_MOVE_RD  = 7'b0010000,
    S_MOVE_WR  = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          hit_q, hit_d;

  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_found_q, res_found_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                found_q, found_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [CW-1:0]    idx_inc;
  logic [CW-1:0]    idx_dec;
  logic             out_free;

  sptf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key   = ram_rdata[ENT_W-1 -: KEY_W];
  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    hit_d        = hit_q;
    op_d         = op_q;
    key_d        = key_q;
    data_d       = data_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    found_d      = found_q;
    count_d      = count_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = operation_i;
          key_d       = sequence_key_i;
          data_d      = entry_data_i;
          idx_d       = '0;
          res_found_d = 1'b0;
          if (operation_i == OP_CLEAR) begin
            fill_d       = '0;
            res_status_d = STAT_INSERTED;
            state_d      = S_RESP;
          end else if (operation_i == OP_ADD || operation_i == OP_REMOVE) begin
            if (fill_q == '0) begin
              pos_d   = '0;
              hit_d   = 1'b0;
              state_d = S_DECIDE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end else begin
            res_status_d = STAT_REMOVED;
            state_d      = S_RESP;
          end
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rd_key >= key_q) begin
          pos_d   = idx_q;
          hit_d   = (rd_key == key_q);
          state_d = S_DECIDE;
        end else if (idx_inc == fill_q) begin
          pos_d   = fill_q;
          hit_d   = 1'b0;
          state_d = S_DECIDE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        res_found_d = hit_q;
        if (op_q == OP_REMOVE) begin
          res_status_d = STAT_REMOVED;
          if (hit_q) begin
            idx_d   = pos_q;
            state_d = S_MOVE_RD;
          end else begin
            state_d = S_RESP;
          end
        end else if (hit_q) begin
          ram_we       = 1'b1;
          ram_waddr    = pos_q[AW-1:0];
          ram_wdata    = {key_q, data_q};
          res_status_d = STAT_REPLACED;
          state_d      = S_RESP;
        end else if (fill_q == CW'(TABLE_DEPTH)) begin
          res_status_d = STAT_FULL;
          state_d      = S_RESP;
        end else begin
          res_status_d = STAT_INSERTED;
          idx_d        = fill_q;
          state_d      = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        if (op_q == OP_REMOVE) begin
          if (idx_inc < fill_q) begin
            ram_raddr = idx_inc[AW-1:0];
            state_d   = S_MOVE_WR;
          end else begin
            fill_d  = fill_q - CW'(1);
            state_d = S_RESP;
          end
        end else begin
          if (idx_q == pos_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[AW-1:0];
            ram_wdata = {key_q, data_q};
            fill_d    = fill_q + CW'(1);
            state_d   = S_RESP;
          end else begin
            ram_raddr = idx_dec[AW-1:0];
            state_d   = S_MOVE_WR;
          end
        end
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = (op_q == OP_REMOVE) ? idx_inc : idx_dec;
        state_d   = S_MOVE_RD;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          found_d     = res_found_q;
          count_d     = COUNT_W'(fill_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    data_q       <= data_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    status_q     <= status_d;
    found_q      <= found_d;
    count_q      <= count_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign key_found_o   = found_q;
  assign entry_count_o = count_q;

endmodule

@@ tb/tb_sorted_prefix_filter_table_unit.sv @@
// tb_sorted_prefix_filter_table_unit: self-checking bench for the sorted filter table,
// scoreboarded against a queue-based table model with random idling on both channels
// depends on sptf_pkg and sorted_prefix_filter_table_unit
module tb_sorted_prefix_filter_table_unit;
  import sptf_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int KEY_POOL_SIZE = 96;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = OP_ADD;
  logic [KEY_W-1:0]    sequence_key = '0;
  logic [DATA_W-1:0]   entry_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                key_found;
  logic [COUNT_W-1:0]  entry_count;

  logic [KEY_W-1:0]  table_keys[$];
  logic [DATA_W-1:0] table_data[$];
  table_result_t     pending_results[$];
  logic [KEY_W-1:0]  key_pool[KEY_POOL_SIZE];
  int                error_count = 0;
  int                idle_cycles = 0;
  bit                idling = 1'b1;
  bit                hold_off_req = 1'b0;

  sorted_prefix_filter_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .sequence_key_i(sequence_key),
    .entry_data_i  (entry_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .key_found_o   (key_found),
    .entry_count_o (entry_count)
  );

  always #5 clk = ~clk;

  function automatic int lower_slot(logic [KEY_W-1:0] key);
    int i;
    i = 0;
    while (i < table_keys.size() && table_keys[i] < key) i++;
    return i;
  endfunction

  function automatic table_result_t apply_update(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                 logic [DATA_W-1:0] data);
    table_result_t r;
    int pos;
    bit hit;
    r.status = STAT_REMOVED;
    r.found = 1'b0;
    case (op)
      OP_CLEAR: begin
        table_keys.delete();
        table_data.delete();
        r.status = STAT_INSERTED;
      end
      OP_ADD, OP_REMOVE: begin
        pos = lower_slot(key);
        hit = (pos < table_keys.size()) && (table_keys[pos] == key);
        r.found = hit;
        if (op == OP_REMOVE) begin
          if (hit) begin
            table_keys.delete(pos);
            table_data.delete(pos);
          end
        end else if (hit) begin
          table_data[pos] = data;
          r.status = STAT_REPLACED;
        end else if (table_keys.size() >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          table_keys.insert(pos, key);
          table_data.insert(pos, data);
          r.status = STAT_INSERTED;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(table_keys.size());
    return r;
  endfunction

  task automatic send_update(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [DATA_W-1:0] data);
    int gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    operation    <= op;
    sequence_key <= key;
    entry_data   <= data;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), apply_update(op, key, data));
  endtask

  task automatic send_random_update(int add_pct, int remove_pct);
    int pick;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) op = OP_ADD;
    else if (pick < add_pct + remove_pct) op = OP_REMOVE;
    else if (pick % 2 == 0) op = OP_CLEAR;
    else op = OP_UNUSED;
    if (op == OP_REMOVE && table_keys.size() != 0 && $urandom_range(0, 1) == 1)
      key = table_keys[$urandom_range(0, table_keys.size() - 1)];
    else if ($urandom_range(0, 9) == 0)
      key = $urandom;
    else
      key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    send_update(op, key, {$urandom, $urandom});
  endtask

  task automatic test_directed();
    send_update(OP_CLEAR, '1, '1);
    send_update(OP_REMOVE, '0, '0);
    send_update(OP_UNUSED, '1, '1);
    send_update(OP_ADD, 32'h8000_0000, '0);
    send_update(OP_ADD, 32'h0000_0000, '1);
    send_update(OP_ADD, 32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A);
    send_update(OP_ADD, 32'h0000_0001, 64'h0123_4567_89AB_CDEF);
    send_update(OP_ADD, 32'hFFFF_FFFE, 64'hFEDC_BA98_7654_3210);
    send_update(OP_ADD, 32'h7FFF_FFFF, '1);
    send_update(OP_ADD, 32'h0000_0000, '0);
    send_update(OP_ADD, 32'hFFFF_FFFF, '1);
    send_update(OP_REMOVE, 32'h8000_0000, '1);
    send_update(OP_REMOVE, 32'h1234_5678, '0);
    send_update(OP_UNUSED, 32'h7FFF_FFFF, '0);
    send_update(OP_REMOVE, 32'h0000_0000, '0);
    send_update(OP_REMOVE, 32'hFFFF_FFFF, '1);
    send_update(OP_ADD, 32'h5555_5555, 64'h5555_5555_5555_5555);
    send_update(OP_ADD, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_update(OP_CLEAR, 32'h5555_5555, '1);
    send_update(OP_REMOVE, 32'h5555_5555, '0);
    send_update(OP_ADD, 32'hAAAA_AAAA, '0);
    send_update(OP_CLEAR, '0, '0);
  endtask

  task automatic test_fill_and_drain(bit descending);
    logic [KEY_W-1:0] keys[$];
    bit used[logic [KEY_W-1:0]];
    logic [KEY_W-1:0] k;
    send_update(OP_CLEAR, $urandom, {$urandom, $urandom});
    while (keys.size() < TABLE_DEPTH) begin
      k = $urandom;
      if (!used.exists(k)) begin
        used[k] = 1'b1;
        keys.insert(keys.size(), k);
      end
    end
    if (descending) keys.rsort();
    foreach (keys[i]) send_update(OP_ADD, keys[i], {$urandom, $urandom});
    // table full: new keys dropped, existing key still replaced
    send_update(OP_ADD, $urandom, {$urandom, $urandom});
    send_update(OP_ADD, $urandom, {$urandom, $urandom});
    send_update(OP_ADD, keys[$urandom_range(0, TABLE_DEPTH - 1)], {$urandom, $urandom});
    send_update(OP_REMOVE, $urandom, {$urandom, $urandom});
    keys.shuffle();
    foreach (keys[i]) send_update(OP_REMOVE, keys[i], {$urandom, $urandom});
    send_update(OP_REMOVE, $urandom, {$urandom, $urandom});
  endtask

  task automatic test_random_mix();
    int add_pct[6] = '{55, 75, 45, 60, 80, 50};
    int remove_pct[6] = '{40, 22, 50, 35, 18, 45};
    logic [KEY_W-1:0] base;
    for (int phase = 0; phase < 6; phase++) begin
      base = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++)
        key_pool[i] = (phase % 2 == 1) ? base + KEY_W'(i) : KEY_W'($urandom);
      repeat (230) send_random_update(add_pct[phase], remove_pct[phase]);
    end
  endtask

  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    repeat (30) send_random_update(60, 35);
  endtask

  task automatic test_steady_stream();
    idling = 1'b0;
    repeat (200) send_random_update(55, 40);
  endtask

  initial begin : result_stall_driver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_off_req) begin
        stall_left = HOLD_OFF_CYCLES - 1;
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    table_result_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d key_found %0d entry_count %0d",
               status, key_found, entry_count);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        if (status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status);
          error_count++;
        end
        if (key_found !== exp.found) begin
          $error("key_found: expected %0d, got %0d", exp.found, key_found);
          error_count++;
        end
        if (entry_count !== exp.count) begin
          $error("entry_count: expected %0d, got %0d", exp.count, entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_drain(1'b1);
    test_random_mix();
    test_fill_and_drain(1'b0);
    test_output_hold_off();
    test_steady_stream();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sptf_pkg.sv
src/sptf_ram.sv
src/sorted_prefix_filter_table_unit.sv
tb/tb_sorted_prefix_filter_table_unit.sv
